// File: hw/rtl/bide_pkg.sv
// ----------------------------------------------------------------------------
// bide_pkg
// Shared types and constants for the insert/delete edit distance engine.
// ----------------------------------------------------------------------------
package bide_pkg;

    localparam logic [1:0] ACT_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] ACT_APPEND_SECOND = 2'd1;
    localparam logic [1:0] ACT_COMPUTE       = 2'd2;
    localparam logic [1:0] ACT_CLEAR         = 2'd3;

    localparam int         DIST_W             = 7;
    localparam int         CFG_ADDR_W         = 3;
    localparam int         CFG_DATA_W         = 32;
    localparam logic       REG_MAX_DISTANCE   = 1'b0;
    localparam logic [6:0] RESET_MAX_DISTANCE = 7'd64;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DIST_W-1:0] distance;
    } bide_result_t;

endpackage

// File: hw/rtl/bide_ram.sv
// ----------------------------------------------------------------------------
// bide_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bide_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/bide_search.sv
// ----------------------------------------------------------------------------
// bide_search
// Diagonal wave sequencer: one compare/add unit walks waves, diagonals and
// slides, one wave RAM holds the furthest reach per diagonal.
// ----------------------------------------------------------------------------
module bide_search #(
    parameter int MAX_LEN  = 256,
    parameter int MAX_DIST = 64,
    parameter int CELL_W   = 32,
    localparam int LW      = $clog2(MAX_LEN + 1),
    localparam int LAW     = $clog2(MAX_LEN)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [LW-1:0]               n,
    input  logic [LW-1:0]               m,
    input  logic [bide_pkg::DIST_W-1:0] max_distance,
    output logic [LAW-1:0]              first_addr,
    output logic [LAW-1:0]              second_addr,
    input  logic [CELL_W-1:0]           first_q,
    input  logic [CELL_W-1:0]           second_q,
    output logic                        busy,
    output bide_pkg::bide_result_t      result
);
    import bide_pkg::*;

    localparam int WB     = $clog2(MAX_LEN + MAX_DIST + 2);
    localparam int HW0    = $clog2(MAX_DIST + 2);
    localparam int HW     = ((HW0 > DIST_W) ? HW0 : DIST_W) + 1;
    localparam int SW     = ((WB > HW) ? WB : HW) + 2;
    localparam int WDEPTH = 2 * MAX_DIST + 1;
    localparam int WAW    = $clog2(WDEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_START,
        S_ISSUE,
        S_CMP,
        S_STORE
    } state_t;

    state_t              state_reg, state_next;
    logic [HW-1:0]       h_reg, h_next;
    logic [HW-1:0]       limit_reg, limit_next;
    logic signed [SW-1:0] d_reg, d_next;
    logic signed [SW-1:0] a_reg, a_next;
    logic [WB-1:0]       left_reg, left_next;
    bide_result_t        result_reg, result_next;

    logic signed [SW-1:0] h_s, n_s, m_s, b_s, q_s, left_s;
    logic signed [SW-1:0] rd_idx, wr_idx;
    logic [HW-1:0]        max_ext;
    logic                 wave_we;
    logic [WB-1:0]        wave_q;

    assign h_s    = $signed({{(SW - HW){1'b0}}, h_reg});
    assign n_s    = $signed({{(SW - LW){1'b0}}, n});
    assign m_s    = $signed({{(SW - LW){1'b0}}, m});
    assign q_s    = $signed({{(SW - WB){1'b0}}, wave_q});
    assign left_s = $signed({{(SW - WB){1'b0}}, left_reg});
    assign b_s    = a_reg - d_reg;
    assign rd_idx = d_reg + SW'(MAX_DIST + 1);
    assign wr_idx = d_reg + SW'(MAX_DIST);
    assign max_ext = {{(HW - DIST_W){1'b0}}, max_distance};

    assign first_addr  = a_reg[LAW-1:0];
    assign second_addr = b_s[LAW-1:0];
    assign wave_we     = (state_reg == S_STORE);
    assign busy        = (state_reg != S_IDLE);
    assign result      = result_reg;

    bide_ram #(
        .WIDTH (WB),
        .DEPTH (WDEPTH)
    ) u_wave_ram (
        .clk   (clk),
        .we    (wave_we),
        .waddr (wr_idx[WAW-1:0]),
        .wdata (a_reg[WB-1:0]),
        .raddr (rd_idx[WAW-1:0]),
        .rdata (wave_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        h_next      = h_reg;
        limit_next  = limit_reg;
        d_next      = d_reg;
        a_next      = a_reg;
        left_next   = left_reg;
        result_next = result_reg;
        result_next.valid = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    h_next     = '0;
                    d_next     = '0;
                    a_next     = '0;
                    limit_next = (max_ext > HW'(MAX_DIST)) ? HW'(MAX_DIST) : max_ext;
                    state_next = S_ISSUE;
                end
            end
            S_FETCH:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                if (d_reg == -h_s)
                begin
                    a_next = q_s;
                end
                else if (d_reg == h_s)
                begin
                    a_next = left_s + SW'(1);
                end
                else if (left_s < q_s)
                begin
                    a_next = q_s;
                end
                else
                begin
                    a_next = left_s + SW'(1);
                end
                left_next  = wave_q;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if ((a_reg < n_s) && (b_s >= 0) && (b_s < m_s))
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_STORE;
                end
            end
            S_CMP:
            begin
                if (first_q == second_q)
                begin
                    a_next     = a_reg + SW'(1);
                    state_next = S_ISSUE;
                end
                else
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                if ((a_reg >= n_s) && (b_s >= m_s))
                begin
                    result_next.valid    = 1'b1;
                    result_next.found    = 1'b1;
                    result_next.distance = h_reg[DIST_W-1:0];
                    state_next           = S_IDLE;
                end
                else if (d_reg < h_s)
                begin
                    d_next     = d_reg + SW'(2);
                    state_next = S_FETCH;
                end
                else if (h_reg == limit_reg)
                begin
                    result_next.valid    = 1'b1;
                    result_next.found    = 1'b0;
                    result_next.distance = '0;
                    state_next           = S_IDLE;
                end
                else
                begin
                    h_next     = h_reg + HW'(1);
                    d_next     = -(h_s + SW'(1));
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            h_reg      <= '0;
            limit_reg  <= '0;
            d_reg      <= '0;
            a_reg      <= '0;
            left_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            h_reg      <= h_next;
            limit_reg  <= limit_next;
            d_reg      <= d_next;
            a_reg      <= a_next;
            left_reg   <= left_next;
            result_reg <= result_next;
        end
    end

endmodule

// File: hw/rtl/banded_insert_delete_edit_distance.sv
// ----------------------------------------------------------------------------
// banded_insert_delete_edit_distance
// Insert/delete edit distance between two loaded cell sequences.
//
//   channel   direction  handshake                  payload
//   request   in         start / busy               action, cell_x, cell_y
//   result    out        done (one-cycle strobe)    found, distance
//   config    in         APB psel/penable/pready    max_distance at 0x0
//
// Append and clear requests are taken without raising busy; busy stays low.
// Compute walks waves h = 0..limit; each diagonal is seeded in S_FETCH, S_START
// (not at h = 0), slides via S_ISSUE and S_CMP per cell pair (registered cell RAM
// read), leaves from S_ISSUE when the slide runs off a sequence end, then S_STORE.
// done pulses as busy falls; a new request may be issued in that cycle.
// Reset: lengths cleared, max_distance = 64. The receiver cannot stall.
// ----------------------------------------------------------------------------
module banded_insert_delete_edit_distance #(
    parameter int MAX_LEN    = 256,
    parameter int MAX_DIST   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [15:0]                     cell_x,
    input  logic [15:0]                     cell_y,
    output logic                            done,
    output logic                            found,
    output logic [bide_pkg::DIST_W-1:0]     distance,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bide_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bide_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bide_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import bide_pkg::*;

    localparam int CW     = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int CELL_W = 2 * CW;
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int LAW    = $clog2(MAX_LEN);

    logic [DIST_W-1:0] max_distance_reg;
    logic [LW-1:0]     first_len_reg, first_len_next;
    logic [LW-1:0]     second_len_reg, second_len_next;

    logic              accept, cfg_write, first_we, second_we;
    logic [CELL_W-1:0] cell_word, first_q, second_q;
    logic [LAW-1:0]    first_addr, second_addr;
    bide_result_t      result;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cell_word = {cell_y[CW-1:0], cell_x[CW-1:0]};
    assign first_we  = accept && (action == ACT_APPEND_FIRST) && (first_len_reg < LW'(MAX_LEN));
    assign second_we = accept && (action == ACT_APPEND_SECOND)
                       && (second_len_reg < LW'(MAX_LEN));

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_DISTANCE)
                      ? {{(CFG_DATA_W - DIST_W){1'b0}}, max_distance_reg} : '0;
    assign done     = result.valid;
    assign found    = result.found;
    assign distance = result.distance;

    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        if (accept && (action == ACT_CLEAR))
        begin
            first_len_next  = '0;
            second_len_next = '0;
        end
        if (first_we)
        begin
            first_len_next = first_len_reg + LW'(1);
        end
        if (second_we)
        begin
            second_len_next = second_len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= RESET_MAX_DISTANCE;
            first_len_reg    <= '0;
            second_len_reg   <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_MAX_DISTANCE))
            begin
                max_distance_reg <= pwdata[DIST_W-1:0];
            end
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
        end
    end

    bide_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_LEN)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_len_reg[LAW-1:0]),
        .wdata (cell_word),
        .raddr (first_addr),
        .rdata (first_q)
    );

    bide_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_LEN)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_len_reg[LAW-1:0]),
        .wdata (cell_word),
        .raddr (second_addr),
        .rdata (second_q)
    );

    bide_search #(
        .MAX_LEN  (MAX_LEN),
        .MAX_DIST (MAX_DIST),
        .CELL_W   (CELL_W)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (accept && (action == ACT_COMPUTE)),
        .n            (first_len_reg),
        .m            (second_len_reg),
        .max_distance (max_distance_reg),
        .first_addr   (first_addr),
        .second_addr  (second_addr),
        .first_q      (first_q),
        .second_q     (second_q),
        .busy         (busy),
        .result       (result)
    );

endmodule

// File: hw/rtl/bide_checker.sv
// ----------------------------------------------------------------------------
// bide_checker
// Port-level checks on request and result behaviour, bound to the top level.
// ----------------------------------------------------------------------------
module bide_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  action,
    input logic                        done,
    input logic                        found,
    input logic [bide_pkg::DIST_W-1:0] distance
);
    import bide_pkg::*;

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == ACT_COMPUTE) |=> busy)
        else $error("compute request did not raise busy");

    a_busy_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (action == ACT_COMPUTE)))
        else $error("busy rose without a compute request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a search");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> (distance == '0))
        else $error("not-found result with non-zero distance");

endmodule

bind banded_insert_delete_edit_distance bide_checker u_checker (.*);

// File: test/tb_banded_insert_delete_edit_distance.sv
// ----------------------------------------------------------------------------
// tb_banded_insert_delete_edit_distance
// Self-checking bench for the insert/delete edit distance engine. Append,
// clear and compute requests are issued in random bursts; every compute
// result is checked against a greedy wave search kept inside the bench.
// max_distance is swept over its extremes through the APB port and read back.
// ----------------------------------------------------------------------------
module tb_banded_insert_delete_edit_distance;
    import bide_pkg::*;

    localparam int SEQ_CAPACITY   = 256;
    localparam int DIST_CAP       = 64;
    localparam int CENTRE         = DIST_CAP;
    localparam int RUN_LIMIT      = 50_000_000;
    localparam int PHASE_REQUESTS = 260;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] x;
        logic [15:0] y;
        bit          drain;
    } request_t;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] distance;
    } outcome_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic [1:0]            action   = ACT_APPEND_FIRST;
    logic [15:0]           cell_x   = '0;
    logic [15:0]           cell_y   = '0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic                  busy;
    logic                  done;
    logic                  found;
    logic [DIST_W-1:0]     distance;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [31:0] first_cells [SEQ_CAPACITY];
    logic [31:0] second_cells [SEQ_CAPACITY];
    int          first_count    = 0;
    int          second_count   = 0;
    logic [6:0]  distance_limit = RESET_MAX_DISTANCE;

    request_t    pending_requests[$];
    outcome_t    expected_outcomes[$];
    request_t    active_request;
    logic [31:0] cell_pool[$];
    bit          wild_cells;
    int          queued_total   = 0;
    int          accepted_total = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 4;
    int          gap_left       = 0;
    bit          hold_start;
    bit          issue_now;
    logic [6:0]  phase_limits [7];
    int          phase_end;

    banded_insert_delete_edit_distance u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .cell_x   (cell_x),
        .cell_y   (cell_y),
        .done     (done),
        .found    (found),
        .distance (distance),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < 50)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Furthest first index reached on diagonal d, starting from a.
    function automatic int slide_reach(int a, int d);
        int b;
        b = a - d;
        while (a >= 0 && b >= 0 && a < first_count && b < second_count
               && first_cells[a] == second_cells[b])
        begin
            a++;
            b++;
        end
        return a;
    endfunction

    // Returns the edit distance, or -1 when beyond the search limit.
    function automatic int wave_search();
        int prev_reach [2*DIST_CAP+1];
        int cur_reach [2*DIST_CAP+1];
        int cap;
        int a;
        cap = (distance_limit > DIST_CAP) ? DIST_CAP : int'(distance_limit);
        cur_reach[CENTRE] = slide_reach(0, 0);
        if (cur_reach[CENTRE] >= first_count && cur_reach[CENTRE] >= second_count)
            return 0;
        prev_reach = cur_reach;
        for (int h = 1; h <= cap; h++)
        begin
            for (int d = -h; d <= h; d += 2)
            begin
                if (d == -h)
                    a = prev_reach[d + 1 + CENTRE];
                else if (d == h)
                    a = prev_reach[d - 1 + CENTRE] + 1;
                else if (prev_reach[d - 1 + CENTRE] < prev_reach[d + 1 + CENTRE])
                    a = prev_reach[d + 1 + CENTRE];
                else
                    a = prev_reach[d - 1 + CENTRE] + 1;
                a = slide_reach(a, d);
                cur_reach[d + CENTRE] = a;
                if (a >= first_count && a - d >= second_count)
                    return h;
            end
            prev_reach = cur_reach;
        end
        return -1;
    endfunction

    task automatic apply_request(request_t req);
        int       edit_len;
        outcome_t outcome;
        case (req.action)
            ACT_APPEND_FIRST:
            begin
                if (first_count < SEQ_CAPACITY)
                begin
                    first_cells[first_count] = {req.x, req.y};
                    first_count++;
                end
            end
            ACT_APPEND_SECOND:
            begin
                if (second_count < SEQ_CAPACITY)
                begin
                    second_cells[second_count] = {req.x, req.y};
                    second_count++;
                end
            end
            ACT_CLEAR:
            begin
                first_count  = 0;
                second_count = 0;
            end
            ACT_COMPUTE:
            begin
                edit_len = wave_search();
                outcome.found    = (edit_len >= 0);
                outcome.distance = (edit_len >= 0) ? DIST_W'(edit_len) : '0;
                expected_outcomes.insert(expected_outcomes.size(), outcome);
            end
        endcase
    endtask

    // Request driver: bursts with random gaps; a drain-marked request waits
    // until every outstanding result has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            hold_start = start && busy;
            issue_now  = 1'b0;
            if (start && !busy)
            begin
                apply_request(active_request);
                accepted_total++;
            end
            if (!hold_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_requests.size() > 0
                         && (!pending_requests[0].drain
                             || (expected_outcomes.size() == 0 && !done)))
                begin
                    issue_now      = 1'b1;
                    active_request = pending_requests.pop_front();
                    action <= active_request.action;
                    cell_x <= active_request.x;
                    cell_y <= active_request.y;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        case ($urandom_range(0, 5))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(15, 30);
                            default: gap_left = $urandom_range(1, 5);
                        endcase
                    end
                end
            end
            start <= hold_start || issue_now;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
                report_mismatch("unrequested result", 1, 0);
            else
            begin
                if (found !== expected_outcomes[0].found)
                    report_mismatch("found", found, expected_outcomes[0].found);
                if (distance !== expected_outcomes[0].distance)
                    report_mismatch("distance", distance, expected_outcomes[0].distance);
                void'(expected_outcomes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_request(logic [1:0] act, logic [15:0] x, logic [15:0] y,
                                 bit drain = 1'b0);
        request_t req;
        req.action = act;
        req.x      = x;
        req.y      = y;
        req.drain  = drain;
        pending_requests.insert(pending_requests.size(), req);
        queued_total++;
    endtask

    // Optional write with junk in the unused data bits, then read-back.
    task automatic access_limit_register(bit write_it, logic [6:0] value);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        if (write_it)
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_MAX_DISTANCE, 2'b00};
            pwdata  <= {junk[CFG_DATA_W-1:7], value};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            distance_limit = value;
        end
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_MAX_DISTANCE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== CFG_DATA_W'(distance_limit))
            report_mismatch("max_distance read-back", prdata, distance_limit);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_until_idle();
        while (accepted_total != queued_total || expected_outcomes.size() != 0 || start)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_cell();
        if (wild_cells || cell_pool.size() == 0)
            return $urandom;
        return cell_pool[$urandom_range(0, cell_pool.size() - 1)];
    endfunction

    // One load/compute sequence: a small cell alphabet with near misses,
    // second sequence mostly an edited copy of the first.
    task automatic queue_random_case(int min_len, int max_len);
        logic [31:0] seq_a[$];
        logic [31:0] seq_b[$];
        logic [31:0] entry;
        int          ia;
        int          ib;
        cell_pool.delete();
        wild_cells = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(1, 6))
        begin
            entry = $urandom;
            if (cell_pool.size() > 0)
            begin
                case ($urandom_range(0, 2))
                    0:       entry[31:16] = cell_pool[$][31:16];
                    1:       entry[15:0]  = cell_pool[$][15:0];
                    default: ;
                endcase
            end
            cell_pool.insert(cell_pool.size(), entry);
        end
        repeat ($urandom_range(min_len, max_len))
            seq_a.insert(seq_a.size(), pick_cell());
        if ($urandom_range(0, 9) < 7)
        begin
            seq_b = seq_a;
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(0, 1) == 0 && seq_b.size() > 0)
                    seq_b.delete($urandom_range(0, seq_b.size() - 1));
                else
                    seq_b.insert($urandom_range(0, seq_b.size()), pick_cell());
            end
        end
        else
        begin
            repeat ($urandom_range(min_len, max_len))
                seq_b.insert(seq_b.size(), pick_cell());
        end
        if ($urandom_range(0, 7) != 0)
            queue_request(ACT_CLEAR, $urandom, $urandom);
        ia = 0;
        ib = 0;
        while (ia < seq_a.size() || ib < seq_b.size())
        begin
            if ($urandom_range(0, 39) == 0)
                queue_request(ACT_COMPUTE, $urandom, $urandom);
            if (ia < seq_a.size() && (ib >= seq_b.size() || $urandom_range(0, 1) == 0))
            begin
                queue_request(ACT_APPEND_FIRST, seq_a[ia][31:16], seq_a[ia][15:0]);
                ia++;
            end
            else
            begin
                queue_request(ACT_APPEND_SECOND, seq_b[ib][31:16], seq_b[ib][15:0]);
                ib++;
            end
        end
        queue_request(ACT_COMPUTE, $urandom, $urandom, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 5) == 0)
            queue_request(ACT_COMPUTE, $urandom, $urandom);
        if ($urandom_range(0, 9) == 0)
            queue_request(2'($urandom), $urandom, $urandom);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        access_limit_register(1'b0, '0);

        // directed: empty sequences, one side empty, near-miss cells
        queue_request(ACT_COMPUTE, 16'h0000, 16'h0000);
        queue_request(ACT_APPEND_FIRST, 16'h0000, 16'h0000);
        queue_request(ACT_COMPUTE, 16'hFFFF, 16'hFFFF);
        queue_request(ACT_APPEND_SECOND, 16'hFFFF, 16'hFFFF);
        queue_request(ACT_COMPUTE, 16'h0000, 16'hFFFF);
        queue_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        queue_request(ACT_APPEND_FIRST, 16'hFFFF, 16'h0000);
        queue_request(ACT_APPEND_SECOND, 16'hFFFF, 16'hFFFF);
        queue_request(ACT_APPEND_SECOND, 16'h0000, 16'h0000);
        queue_request(ACT_COMPUTE, 16'hFFFF, 16'h0000);
        queue_request(ACT_CLEAR, 16'h0000, 16'h0000);
        queue_request(ACT_APPEND_FIRST, 16'hA5A5, 16'h5A5A);
        queue_request(ACT_APPEND_SECOND, 16'hA5A5, 16'h5A5A);
        queue_request(ACT_APPEND_FIRST, 16'h0000, 16'hFFFF);
        queue_request(ACT_APPEND_SECOND, 16'h0001, 16'hFFFF);
        queue_request(ACT_COMPUTE, 16'h5A5A, 16'hA5A5);
        queue_request(ACT_CLEAR, 16'h1234, 16'h5678);
        queue_request(ACT_APPEND_SECOND, 16'h1234, 16'hABCD);
        queue_request(ACT_COMPUTE, 16'h0000, 16'h0000);
        queue_request(ACT_COMPUTE, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_request(ACT_CLEAR, 16'h0000, 16'h0000);
        queue_request(ACT_COMPUTE, 16'h0000, 16'h0000, 1'b1);
        wait_until_idle();

        phase_limits[0] = 7'd0;
        phase_limits[1] = 7'd127;
        phase_limits[2] = 7'd1;
        phase_limits[3] = 7'($urandom_range(2, 9));
        phase_limits[4] = 7'd64;
        phase_limits[5] = 7'd70;
        phase_limits[6] = 7'($urandom_range(10, 63));
        foreach (phase_limits[i])
        begin
            access_limit_register(1'b1, phase_limits[i]);
            phase_end = queued_total + PHASE_REQUESTS;
            // overfilled sequences at limit 64 (cells past capacity must be dropped), long ones at 127
            if (phase_limits[i] == 7'd64)
                queue_random_case(258, 266);
            if (phase_limits[i] == 7'd127)
                queue_random_case(90, 140);
            while (queued_total < phase_end)
                queue_random_case(0, ($urandom_range(0, 7) == 0) ? 40 : 12);
            wait_until_idle();
        end
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/bide_pkg.sv
hw/rtl/bide_ram.sv
hw/rtl/bide_search.sv
hw/rtl/banded_insert_delete_edit_distance.sv
hw/rtl/bide_checker.sv
test/tb_banded_insert_delete_edit_distance.sv
